// ===== sv/rme_pkg.sv =====
// package for the modular exponentiation block
// holds the controller state type and register index codes; no dependencies
package rme_pkg;
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DONE
	} state_t;

	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;
endpackage

// ===== sv/rme_cell.sv =====
// one shift-add step of a modular multiply: conditional add and doubling mod m
// uses no package items
module rme_cell #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         ld,
	input  logic [W-1:0] a_in,
	input  logic [W-1:0] acc_in,
	input  logic         bit_in,
	input  logic [W-1:0] m,
	output logic [W-1:0] a_q,
	output logic [W-1:0] acc_q
);
	logic [W:0] sum_acc, sum_a;
	logic [W-1:0] acc_nx, a_nx;

	always_comb begin
		sum_acc = {1'b0, acc_in} + {1'b0, a_in};
		if (!bit_in)
			acc_nx = acc_in;
		else if (sum_acc >= {1'b0, m})
			acc_nx = W'(sum_acc - {1'b0, m});
		else
			acc_nx = sum_acc[W-1:0];
		sum_a = {a_in, 1'b0};
		if (sum_a >= {1'b0, m})
			a_nx = W'(sum_a - {1'b0, m});
		else
			a_nx = sum_a[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			a_q   <= a_nx;
			acc_q <= acc_nx;
		end
	end
endmodule

// ===== sv/rme_mulmod.sv =====
// modular multiplier: a row of two cells, each taking one multiplier bit a cycle
// depends on rme_cell
module rme_mulmod #(
	parameter int W = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output logic         done,
	output logic [W-1:0] p
);
	localparam int STEPS = (W + 1) / 2;
	localparam int CW = $clog2(STEPS + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [2*STEPS-1:0] b_q;
	logic [W-1:0] a0, acc0, a1, acc1, a1_o, acc1_o;
	logic first;

	assign first = start;
	assign a0 = first ? a : a1_o;
	assign acc0 = first ? '0 : acc1_o;

	// cell 0 works bit 2k combinationally feeding cell 1 bit 2k+1
	logic [W:0] s0acc, s0a;
	always_comb begin
		s0acc = {1'b0, acc0} + {1'b0, a0};
		if (!(first ? b[0] : b_q[0]))
			acc1 = acc0;
		else if (s0acc >= {1'b0, m})
			acc1 = W'(s0acc - {1'b0, m});
		else
			acc1 = s0acc[W-1:0];
		s0a = {a0, 1'b0};
		if (s0a >= {1'b0, m})
			a1 = W'(s0a - {1'b0, m});
		else
			a1 = s0a[W-1:0];
	end

	logic [2*STEPS-1:0] b_ext;
	assign b_ext = (2*STEPS)'(b);

	rme_cell #(.W(W)) u_cell (
		.clk(clk), .ld(start || busy_q), .a_in(a1), .acc_in(acc1),
		.bit_in(first ? b_ext[1] : b_q[1]), .m(m), .a_q(a1_o), .acc_q(acc1_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (STEPS > 1);
			cnt_q  <= CW'(1);
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			b_q <= b_ext >> 2;
		else if (busy_q)
			b_q <= b_q >> 2;
	end

	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (start && STEPS == 1) || (busy_q && cnt_q == CW'(STEPS - 1));
	end
	assign done = done_q;
	assign p = acc1_o;
endmodule

// ===== sv/rsa_modular_exponentiation.sv =====
// a flagged message gives its result beat in the cycle after it is taken; other messages
// get theirs after a square for every exponent bit and a multiply for every set exponent bit
// the modular multiplies run on the two-cell multiplier row
// one message at a time; a new beat is taken the cycle after the result beat has left
// reset clears control and sets exponent to 1, modulus to 2
// depends on rme_pkg, rme_mulmod
module rsa_modular_exponentiation #(
	parameter int KEY_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [KEY_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KEY_BITS-1:0] message,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_BITS-1:0] result,
	output logic                bad_input
);
	localparam int BW = $clog2(KEY_BITS + 1);

	logic [KEY_BITS-1:0] exp_q, mod_q, base_q, acc_q, ex_q;
	logic [BW-1:0] bit_q;
	logic phase_q; // 0 multiply acc, 1 square base
	rme_pkg::state_t state_q, state_d;
	logic bad_q;
	logic start, mdone, go;
	logic [KEY_BITS-1:0] ma, mb, mp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= KEY_BITS'(1);
			mod_q <= KEY_BITS'(2);
		end else if (cfg_we) begin
			if (cfg_index == rme_pkg::REG_EXPONENT)
				exp_q <= cfg_data;
			else
				mod_q <= cfg_data;
		end
	end

	assign go = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rme_pkg::ST_IDLE: if (go) state_d = (message >= mod_q) ? rme_pkg::ST_DONE
					: rme_pkg::ST_MUL;
			rme_pkg::ST_MUL: if (mdone && phase_q && bit_q == BW'(KEY_BITS - 1))
					state_d = rme_pkg::ST_DONE;
			rme_pkg::ST_DONE: if (!out_stall) state_d = rme_pkg::ST_IDLE;
			default: state_d = rme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != rme_pkg::ST_IDLE);
		out_valid = (state_q == rme_pkg::ST_DONE);
	end

	assign ma = phase_q ? base_q : acc_q;
	assign mb = base_q;

	rme_mulmod #(.W(KEY_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(start), .a(ma), .b(mb), .m(mod_q),
		.done(mdone), .p(mp)
	);

	logic pend_q;
	// a multiply is skipped when the exponent bit is clear
	assign start = (state_q == rme_pkg::ST_MUL) && !pend_q && (phase_q || ex_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rme_pkg::ST_IDLE;
			pend_q  <= 1'b0;
			phase_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				pend_q  <= 1'b0;
				phase_q <= 1'b0;
				bit_q   <= '0;
			end else if (state_q == rme_pkg::ST_MUL) begin
				if (start)
					pend_q <= 1'b1;
				else if (!phase_q && !pend_q)
					phase_q <= 1'b1;
				else if (mdone) begin
					pend_q <= 1'b0;
					if (phase_q) begin
						phase_q <= 1'b0;
						bit_q   <= bit_q + 1'b1;
					end else
						phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			base_q <= message;
			ex_q   <= exp_q;
			acc_q  <= (mod_q == KEY_BITS'(1)) ? '0 : KEY_BITS'(1);
			bad_q  <= (message >= mod_q);
		end else if (state_q == rme_pkg::ST_MUL && mdone && pend_q) begin
			if (phase_q) begin
				base_q <= mp;
				ex_q   <= ex_q >> 1;
			end else
				acc_q <= mp;
		end
	end

	assign result = bad_q ? '0 : acc_q;
	assign bad_input = bad_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rme_pkg::ST_MUL) |-> in_stall)
		else $error("input beat accepted during exponentiation");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result)))
		else $error("result beat changed while stalled");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_input) |-> (result == '0))
		else $error("flagged message gave nonzero result");
endmodule
